// File: rtl/dtbc_pkg.sv
// shared types, constants and the capacity table for the blocks-per-track unit
`timescale 1ns / 1ps

package dtbc_pkg;

  // default width of track length and block size
  localparam int SIZE_WIDTH_DEF = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TABLE_DEVICE = 2'd0,
    CFG_CELL_DEVICE  = 2'd1,
    CFG_FLAT_DEVICE  = 2'd2
  } cfg_idx_t;

  // reset device codes
  localparam logic [7:0] CODE_TABLE_RST = 8'd15;
  localparam logic [7:0] CODE_CELL_RST  = 8'd14;
  localparam logic [7:0] CODE_FLAT_RST  = 8'd11;

  // geometry constants
  localparam int unsigned TABLE_MAX_BLOCK  = 56664;
  localparam int unsigned CELL_TRACK_CELLS = 1499;
  localparam int unsigned CELL_OVERHEAD    = 15;
  localparam int unsigned CELL_EXTRA       = 12;
  localparam int unsigned CELL_ROUND       = 31;
  localparam int unsigned CELL_SHIFT       = 5;
  localparam int unsigned FLAT_TRACK_BYTES = 19254;
  localparam int unsigned FLAT_OVERHEAD    = 185;

  // descending table of minimum block lengths and their counts
  localparam int CAP_ROWS = 63;
  localparam int COUNT_W  = 7;

  localparam logic [15:0] CAP_LEAST [CAP_ROWS] = '{
    16'd27999, 16'd18453, 16'd13683, 16'd10797, 16'd8907,
    16'd7549,  16'd6519,  16'd5727,  16'd5065,  16'd4567,
    16'd4137,  16'd3769,  16'd3441,  16'd3175,  16'd2943,
    16'd2711,  16'd2547,  16'd2377,  16'd2213,  16'd2083,
    16'd1947,  16'd1851,  16'd1749,  16'd1647,  16'd1551,
    16'd1483,  16'd1387,  16'd1319,  16'd1251,  16'd1183,
    16'd1155,  16'd1087,  16'd1019,  16'd985,   16'd951,
    16'd889,   16'd855,   16'd821,   16'd787,   16'd753,
    16'd719,   16'd691,   16'd657,   16'd623,   16'd589,
    16'd555,   16'd521,   16'd487,   16'd459,   16'd425,
    16'd391,   16'd357,   16'd323,   16'd289,   16'd255,
    16'd227,   16'd193,   16'd159,   16'd125,   16'd91,
    16'd57,    16'd23,    16'd1
  };

  localparam logic [COUNT_W-1:0] CAP_COUNT [CAP_ROWS] = '{
    7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,  7'd10,
    7'd11, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20,
    7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30,
    7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38, 7'd39, 7'd40,
    7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd48, 7'd49, 7'd50, 7'd52,
    7'd54, 7'd55, 7'd57, 7'd59, 7'd61, 7'd64, 7'd66, 7'd69, 7'd72, 7'd75,
    7'd78, 7'd82, 7'd86
  };

  // sideband that travels down the divider chain with each query
  typedef struct packed {
    logic               valid;
    logic               exact;
    logic               force_zero;
    logic               use_table;
    logic [COUNT_W-1:0] table_count;
  } side_t;

  // parallel compare against every row, first matching row wins
  function automatic logic [COUNT_W-1:0] table_lookup(input logic [31:0] size);
    logic [COUNT_W-1:0] cnt;
    cnt = '0;
    for (int r = CAP_ROWS - 1; r >= 0; r--) begin
      if (size >= {16'd0, CAP_LEAST[r]}) begin
        cnt = CAP_COUNT[r];
      end
    end
    if (size > TABLE_MAX_BLOCK) begin
      cnt = '0;
    end
    return cnt;
  endfunction

endpackage

// File: rtl/dtbc_front.sv
// front stage: device decode, table lookup and dividend/divisor selection
`timescale 1ns / 1ps

module dtbc_front #(
  parameter int SIZE_WIDTH = dtbc_pkg::SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            device_code,
  input  logic [SIZE_WIDTH-1:0] track_length,
  input  logic [SIZE_WIDTH-1:0] block_size,
  input  logic [7:0]            code_table,
  input  logic [7:0]            code_cell,
  input  logic [7:0]            code_flat,
  output dtbc_pkg::side_t       side_out,
  output logic [SIZE_WIDTH:0]   rem_out,
  output logic [SIZE_WIDTH-1:0] nq_out,
  output logic [SIZE_WIDTH:0]   div_out
);
  import dtbc_pkg::*;

  localparam int W  = SIZE_WIDTH;
  localparam int DW = SIZE_WIDTH + 1;

  logic          is_table;
  logic          is_cell;
  logic          is_flat;
  logic [DW-1:0] cell_sum;
  logic [DW-1:0] cell_div;
  logic [DW-1:0] flat_div;
  side_t         side_nxt;
  side_t         side_r;
  logic [W-1:0]  num_nxt;
  logic [W-1:0]  num_r;
  logic [DW-1:0] div_nxt;
  logic [DW-1:0] div_r;

  // device match, table wins over cell, cell over flat
  assign is_table = (device_code == code_table);
  assign is_cell  = (device_code == code_cell);
  assign is_flat  = (device_code == code_flat);

  // cell overhead plus rounded-up cell count, flat overhead plus size
  assign cell_sum = DW'(block_size) + DW'(CELL_EXTRA + CELL_ROUND);
  assign cell_div = (cell_sum >> CELL_SHIFT) + DW'(CELL_OVERHEAD);
  assign flat_div = DW'(block_size) + DW'(FLAT_OVERHEAD);

  // operand select
  always_comb begin
    side_nxt.valid       = take;
    side_nxt.exact       = is_table | is_cell | is_flat;
    side_nxt.force_zero  = (block_size == '0);
    side_nxt.use_table   = is_table;
    side_nxt.table_count = table_lookup(32'(block_size));
    if (is_table) begin
      num_nxt = '0;
      div_nxt = DW'(1);
    end else if (is_cell) begin
      num_nxt = W'(CELL_TRACK_CELLS);
      div_nxt = cell_div;
    end else if (is_flat) begin
      num_nxt = W'(FLAT_TRACK_BYTES);
      div_nxt = flat_div;
    end else begin
      num_nxt = track_length;
      div_nxt = DW'(block_size);
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side_nxt.valid;
    end
    side_r.exact       <= side_nxt.exact;
    side_r.force_zero  <= side_nxt.force_zero;
    side_r.use_table   <= side_nxt.use_table;
    side_r.table_count <= side_nxt.table_count;
    num_r              <= num_nxt;
    div_r              <= div_nxt;
  end

  assign side_out = side_r;
  assign rem_out  = '0;
  assign nq_out   = num_r;
  assign div_out  = div_r;

endmodule

// File: rtl/dtbc_div_cell.sv
// one restoring divider cell: resolves one quotient bit per cycle
`timescale 1ns / 1ps

module dtbc_div_cell #(
  parameter int SIZE_WIDTH = dtbc_pkg::SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtbc_pkg::side_t       side_in,
  input  logic [SIZE_WIDTH:0]   rem_in,
  input  logic [SIZE_WIDTH-1:0] nq_in,
  input  logic [SIZE_WIDTH:0]   div_in,
  output dtbc_pkg::side_t       side_out,
  output logic [SIZE_WIDTH:0]   rem_out,
  output logic [SIZE_WIDTH-1:0] nq_out,
  output logic [SIZE_WIDTH:0]   div_out
);
  import dtbc_pkg::*;

  localparam int W  = SIZE_WIDTH;
  localparam int DW = SIZE_WIDTH + 1;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          q_bit;
  logic [DW-1:0] rem_nxt;
  logic [W-1:0]  nq_nxt;
  side_t         side_r;
  logic [DW-1:0] rem_r;
  logic [W-1:0]  nq_r;
  logic [DW-1:0] div_r;

  // shift in next dividend bit, trial subtract
  assign trial   = {rem_in, nq_in[W-1]};
  assign diff    = trial - {1'b0, div_in};
  assign q_bit   = (trial >= {1'b0, div_in});
  assign rem_nxt = q_bit ? diff[DW-1:0] : trial[DW-1:0];
  assign nq_nxt  = {nq_in[W-2:0], q_bit};

  // hand off to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side_in.valid;
    end
    side_r.exact       <= side_in.exact;
    side_r.force_zero  <= side_in.force_zero;
    side_r.use_table   <= side_in.use_table;
    side_r.table_count <= side_in.table_count;
    rem_r              <= rem_nxt;
    nq_r               <= nq_nxt;
    div_r              <= div_in;
  end

  assign side_out = side_r;
  assign rem_out  = rem_r;
  assign nq_out   = nq_r;
  assign div_out  = div_r;

endmodule

// File: rtl/disk_track_block_capacity_unit.sv
// top level: config registers, divider cell chain and result register
// path: front stage register, then SIZE_WIDTH divider cells, then the result register
// throughput: one query per cycle, busy stays low; the rate is set by the chain of
//   SIZE_WIDTH divider cells, each resolving one quotient bit and passing it on
// reset: synchronous active-low rst_n clears all valid bits and loads the device
//   codes 15, 14 and 11; results are strobed for one cycle, the receiver cannot stall
`timescale 1ns / 1ps

module disk_track_block_capacity_unit #(
  parameter int SIZE_WIDTH = dtbc_pkg::SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [7:0]            in_device_code,
  input  logic [SIZE_WIDTH-1:0] in_track_length,
  input  logic [SIZE_WIDTH-1:0] in_block_size,
  output logic                  out_valid,
  output logic [15:0]           out_blocks_per_track,
  output logic                  out_is_exact,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);
  import dtbc_pkg::*;

  localparam int W   = SIZE_WIDTH;
  localparam int DW  = SIZE_WIDTH + 1;
  localparam int LAT = SIZE_WIDTH + 2;

  logic [7:0]  code_table_r;
  logic [7:0]  code_cell_r;
  logic [7:0]  code_flat_r;
  logic        take;

  side_t         side   [W+1];
  logic [DW-1:0] rem    [W+1];
  logic [W-1:0]  nq     [W+1];
  logic [DW-1:0] div    [W+1];

  logic          sat;
  logic [15:0]   blocks_nxt;
  logic          valid_r;
  logic [15:0]   blocks_r;
  logic          exact_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_table_r <= CODE_TABLE_RST;
      code_cell_r  <= CODE_CELL_RST;
      code_flat_r  <= CODE_FLAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TABLE_DEVICE: code_table_r <= cfg_data;
        CFG_CELL_DEVICE:  code_cell_r  <= cfg_data;
        CFG_FLAT_DEVICE:  code_flat_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode and operand stage
  dtbc_front #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .device_code  (in_device_code),
    .track_length (in_track_length),
    .block_size   (in_block_size),
    .code_table   (code_table_r),
    .code_cell    (code_cell_r),
    .code_flat    (code_flat_r),
    .side_out     (side[0]),
    .rem_out      (rem[0]),
    .nq_out       (nq[0]),
    .div_out      (div[0])
  );

  // divider chain, one cell per quotient bit
  for (genvar i = 0; i < W; i++) begin : g_cell
    dtbc_div_cell #(
      .SIZE_WIDTH (SIZE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .side_in  (side[i]),
      .rem_in   (rem[i]),
      .nq_in    (nq[i]),
      .div_in   (div[i]),
      .side_out (side[i+1]),
      .rem_out  (rem[i+1]),
      .nq_out   (nq[i+1]),
      .div_out  (div[i+1])
    );
  end

  // path select and saturation of the quotient
  assign sat = |(nq[W] >> 16);
  always_comb begin
    if (side[W].force_zero) begin
      blocks_nxt = '0;
    end else if (side[W].use_table) begin
      blocks_nxt = 16'(side[W].table_count);
    end else if (sat) begin
      blocks_nxt = 16'hFFFF;
    end else begin
      blocks_nxt = nq[W][15:0];
    end
  end

  // result register, one-cycle strobe per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= side[W].valid;
    end
    blocks_r <= blocks_nxt;
    exact_r  <= side[W].exact;
  end

  assign out_valid            = valid_r;
  assign out_blocks_per_track = blocks_r;
  assign out_is_exact         = exact_r;

`ifndef ASSERT_OFF
  // every accepted query comes out after the fixed latency
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##LAT out_valid)
    else $error("accepted query did not produce a result on time");

  // no result without a matching query accepted earlier
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, LAT))
    else $error("result strobe without a matching query");

  // zero block size always yields zero blocks
  a_zero_block: assert property (@(posedge clk) disable iff (!rst_n)
    side[W].valid && side[W].force_zero |=> out_valid && out_blocks_per_track == 16'd0)
    else $error("zero block size gave nonzero blocks");

  // table path never exceeds the largest table count
  a_table_max: assert property (@(posedge clk) disable iff (!rst_n)
    side[W].valid && side[W].use_table && !side[W].force_zero
      |=> out_blocks_per_track <= 16'd86 && out_is_exact)
    else $error("table path result out of range");
`endif

endmodule

// File: bench/tb_disk_track_block_capacity_unit.sv
// self-checking bench for the blocks-per-track unit: directed edges, config sweeps, random queries
`timescale 1ns / 1ps

module tb_disk_track_block_capacity_unit;
  import dtbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_TABLE_LEN  = 56664;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  // minimum block length per row and the block count it gives, longest first
  localparam int unsigned ROW_MIN_LEN [63] = '{
    27999, 18453, 13683, 10797, 8907, 7549, 6519, 5727, 5065, 4567,
    4137, 3769, 3441, 3175, 2943, 2711, 2547, 2377, 2213, 2083,
    1947, 1851, 1749, 1647, 1551, 1483, 1387, 1319, 1251, 1183,
    1155, 1087, 1019, 985, 951, 889, 855, 821, 787, 753,
    719, 691, 657, 623, 589, 555, 521, 487, 459, 425,
    391, 357, 323, 289, 255, 227, 193, 159, 125, 91,
    57, 23, 1
  };
  localparam int unsigned ROW_BLOCKS [63] = '{
    1, 2, 3, 4, 5, 6, 7, 8, 9, 10,
    11, 12, 13, 14, 15, 16, 17, 18, 19, 20,
    21, 22, 23, 24, 25, 26, 27, 28, 29, 30,
    31, 32, 33, 34, 35, 36, 37, 38, 39, 40,
    41, 42, 43, 44, 45, 46, 48, 49, 50, 52,
    54, 55, 57, 59, 61, 64, 66, 69, 72, 75,
    78, 82, 86
  };

  typedef struct packed {
    logic [15:0] blocks;
    logic        exact;
  } capacity_t;

  // device codes, expected capacities in flight, and the comparison
  class capacity_scoreboard;
    logic [7:0] table_code;
    logic [7:0] cell_code;
    logic [7:0] flat_code;
    capacity_t  pending[$];
    int         mismatches;

    function new();
      table_code = CODE_TABLE_RST;
      cell_code  = CODE_CELL_RST;
      flat_code  = CODE_FLAT_RST;
      mismatches = 0;
    endfunction

    function void set_code(cfg_idx_t idx, logic [7:0] value);
      case (idx)
        CFG_TABLE_DEVICE: table_code = value;
        CFG_CELL_DEVICE:  cell_code  = value;
        CFG_FLAT_DEVICE:  flat_code  = value;
        default: ;
      endcase
    endfunction

    function capacity_t capacity_of(logic [7:0] dev, logic [15:0] trk, logic [15:0] blk);
      capacity_t   res;
      int unsigned n;
      int unsigned size;
      bit          hit_table;
      bit          hit_cell;
      bit          hit_flat;
      hit_table = (dev == table_code);
      hit_cell  = (dev == cell_code);
      hit_flat  = (dev == flat_code);
      size = 32'(blk);
      n = 0;
      if (size != 0) begin
        if (hit_table) begin
          // first row whose minimum length the block reaches
          if (size <= MAX_TABLE_LEN) begin
            for (int r = 62; r >= 0; r--) begin
              if (size >= ROW_MIN_LEN[r]) n = ROW_BLOCKS[r];
            end
          end
        end else if (hit_cell) begin
          n = 1499 / (15 + (size + 12 + 31) / 32);
        end else if (hit_flat) begin
          n = 19254 / (185 + size);
        end else if (trk != 0) begin
          n = int'(trk) / size;
        end
      end
      if (n > 65535) n = 65535;
      res.blocks = n[15:0];
      res.exact  = hit_table || hit_cell || hit_flat;
      return res;
    endfunction

    function void note_query(logic [7:0] dev, logic [15:0] trk, logic [15:0] blk);
      pending.push_back(capacity_of(dev, trk, blk));
    endfunction

    function void check_result(logic [15:0] blocks, logic exact);
      capacity_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none actual blocks %0d exact %0b",
                 $time, blocks, exact);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (blocks !== want.blocks) begin
        $display("%0t blocks_per_track mismatch: expected %0d actual %0d",
                 $time, want.blocks, blocks);
        mismatches++;
      end
      if (exact !== want.exact) begin
        $display("%0t is_exact mismatch: expected %0b actual %0b", $time, want.exact, exact);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_device_code;
  logic [15:0] in_track_length;
  logic [15:0] in_block_size;
  logic        out_valid;
  logic [15:0] out_blocks_per_track;
  logic        out_is_exact;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  capacity_scoreboard board;
  int idle_cycles;

  disk_track_block_capacity_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_device_code       (in_device_code),
    .in_track_length      (in_track_length),
    .in_block_size        (in_block_size),
    .out_valid            (out_valid),
    .out_blocks_per_track (out_blocks_per_track),
    .out_is_exact         (out_is_exact),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watch every transfer at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_query(in_device_code, in_track_length, in_block_size);
      if (out_valid) board.check_result(out_blocks_per_track, out_is_exact);
      if (cfg_valid && cfg_ready) board.set_code(cfg_idx_t'(cfg_index), cfg_data);
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid || (cfg_valid && cfg_ready))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // present one query and hold it until the unit takes it
  task automatic send_query(logic [7:0] dev, logic [15:0] trk, logic [15:0] blk);
    start           <= 1'b1;
    in_device_code  <= dev;
    in_track_length <= trk;
    in_block_size   <= blk;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic sender_gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // stop sending and wait for every expected capacity to come back
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // one register transfer; cfg_valid stays up for a following write
  task automatic write_code(logic [1:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic set_codes(logic [7:0] tab, logic [7:0] cel, logic [7:0] flt);
    write_code(CFG_TABLE_DEVICE, tab);
    write_code(CFG_CELL_DEVICE, cel);
    write_code(CFG_FLAT_DEVICE, flt);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // random query biased toward the known devices and the table boundaries
  task automatic random_query();
    logic [7:0]  dev;
    logic [15:0] trk;
    logic [15:0] blk;
    int          pick;
    int          row;
    pick = $urandom_range(0, 99);
    if (pick < 25)      dev = board.table_code;
    else if (pick < 45) dev = board.cell_code;
    else if (pick < 65) dev = board.flat_code;
    else                dev = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      blk = 16'd0;
    end else if (pick < 14) begin
      blk = 16'hFFFF;
    end else if (pick < 32) begin
      row = $urandom_range(0, 62);
      blk = 16'(ROW_MIN_LEN[row] - $urandom_range(0, 1));
    end else if (pick < 38) begin
      blk = 16'(MAX_TABLE_LEN - 1 + $urandom_range(0, 2));
    end else if (pick < 70) begin
      blk = 16'($urandom_range(1, 2000));
    end else begin
      blk = 16'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 10)      trk = 16'd0;
    else if (pick < 20) trk = 16'hFFFF;
    else if (pick < 45) trk = 16'($urandom_range(1, 300));
    else                trk = 16'($urandom);
    send_query(dev, trk, blk);
  endtask

  // random stretch with bursts of sender gaps, some stretches without any
  task automatic random_phase(int count, bit with_gaps);
    int gap_pct;
    gap_pct = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) gap_pct = (with_gaps && $urandom_range(0, 2) != 0) ? 12 : 0;
      if ($urandom_range(1, 100) <= gap_pct) sender_gap($urandom_range(1, 19));
      random_query();
    end
    drain();
  endtask

  initial begin
    board           = new();
    idle_cycles     = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_device_code  = '0;
    in_track_length = '0;
    in_block_size   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed edges with the reset codes
    send_query(8'd15, 16'd0, 16'd0);
    send_query(8'd15, 16'd0, 16'd1);
    send_query(8'd15, 16'd500, 16'd22);
    send_query(8'd15, 16'd500, 16'd23);
    send_query(8'd15, 16'hFFFF, 16'd27998);
    send_query(8'd15, 16'hFFFF, 16'd27999);
    send_query(8'd15, 16'd7, 16'd56664);
    send_query(8'd15, 16'd7, 16'd56665);
    send_query(8'd15, 16'd7, 16'hFFFF);
    send_query(8'd14, 16'd9, 16'd0);
    send_query(8'd14, 16'd9, 16'd1);
    send_query(8'd14, 16'd9, 16'd20);
    send_query(8'd14, 16'd9, 16'hFFFF);
    send_query(8'd11, 16'd0, 16'd0);
    send_query(8'd11, 16'd0, 16'd1);
    send_query(8'd11, 16'd0, 16'd19069);
    send_query(8'd11, 16'd0, 16'hFFFF);
    sender_gap(3);
    send_query(8'd0, 16'd0, 16'd5);
    send_query(8'd255, 16'hFFFF, 16'd1);
    send_query(8'd255, 16'hFFFF, 16'hFFFF);
    send_query(8'd12, 16'd100, 16'd0);
    send_query(8'd13, 16'd1, 16'hFFFF);
    send_query(8'hAA, 16'h5555, 16'h00AA);
    send_query(8'h55, 16'hAAAA, 16'h5555);
    random_phase(230, 1'b1);

    // extreme codes, all distinct
    set_codes(8'd0, 8'd255, 8'd128);
    random_phase(250, 1'b1);

    // all codes collide: the table path wins; a spare index must change nothing
    set_codes(8'd255, 8'd255, 8'd255);
    write_code(CFG_SPARE_IDX, 8'd7);
    cfg_valid <= 1'b0;
    @(negedge clk);
    send_query(8'd255, 16'd1000, 16'd23);
    send_query(8'd255, 16'd1000, 16'd0);
    send_query(8'd7, 16'd1000, 16'd3);
    random_phase(240, 1'b1);

    // cell and flat collide: the cell path wins
    set_codes(8'd200, 8'd0, 8'd0);
    send_query(8'd0, 16'd50, 16'd100);
    random_phase(250, 1'b1);

    // random codes
    set_codes(8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(250, 1'b1);

    // back to the reset codes, no idling to the end
    set_codes(8'd15, 8'd14, 8'd11);
    random_phase(300, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, board.pending.size());
    end
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dtbc_pkg.sv
rtl/dtbc_front.sv
rtl/dtbc_div_cell.sv
rtl/disk_track_block_capacity_unit.sv
bench/tb_disk_track_block_capacity_unit.sv
